/* rtl/core/sfr_pkg.sv */
package sfr_pkg;

    // Sizing
    localparam int MAX_PATTERN_BYTES     = 8;
    localparam int MAX_REPLACEMENT_BYTES = 8;
    localparam int WINDOW_CAP            = 8;
    localparam int WIN_IDX_W             = $clog2(WINDOW_CAP);
    localparam int LEN_W                 = 4;
    localparam int CNT_W                 = 16;
    localparam int CFG_W                 = 64;
    localparam int CFG_IDX_W             = 2;

    // Effective length caps: the window never holds more than WINDOW_CAP bytes
    localparam int PLEN_CAP = (MAX_PATTERN_BYTES < WINDOW_CAP) ?
                              MAX_PATTERN_BYTES : WINDOW_CAP;
    localparam int RLEN_CAP = (MAX_REPLACEMENT_BYTES < WINDOW_CAP) ?
                              MAX_REPLACEMENT_BYTES : WINDOW_CAP;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPL,
        ST_FLUSH,
        ST_FINAL
    } t_state;

    // Input word
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             last;
        logic [CNT_W-1:0] replacement_count;
    } t_out_word;

    // Clamp a configured length to a cap
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                   input logic [LEN_W-1:0] cap);
        logic [LEN_W-1:0] r;
        r = (v > cap) ? cap : v;
        return r;
    endfunction

endpackage

/* rtl/core/streaming_find_replace.sv */
// Streaming find-and-replace. Text arrives one word per byte; leftmost,
// non-overlapping occurrences of the configured pattern (up to 8 bytes) are
// replaced by the configured replacement (0 to 8 bytes), other bytes pass
// through, and the final result of a text carries last and the saturating
// replacement count (a bare end marker with byte_valid low if the text
// produces no byte). One byte comparator bank and one emit step are reused
// by a small sequencer, one decision or one emitted byte per cycle while the
// output is not stalled, and the block takes no new word until the current
// one is resolved. The single-word output register holds its word while the
// downstream side stalls. Configuration is taken only while idle and no text
// word is offered; writing pattern_bytes or pattern_length discards any held
// partial match.
module streaming_find_replace
    import sfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // text input
    input  logic                 i_valid,
    input  t_in_word             i_data,
    output logic                 o_stall,
    // result output
    output logic                 o_valid,
    output t_out_word            o_data,
    input  logic                 i_stall,
    // configuration writes
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready
);

    // Configuration registers
    logic [CFG_W-1:0] r_pat;
    logic [LEN_W-1:0] r_plen_raw;
    logic [CFG_W-1:0] r_rep;
    logic [LEN_W-1:0] r_rlen_raw;

    // Control and data state
    t_state               r_state, n_state;
    logic [7:0]           r_win [WINDOW_CAP];
    logic [7:0]           n_win [WINDOW_CAP];
    logic [LEN_W-1:0]     r_len, n_len;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_end, n_end;
    logic [WIN_IDX_W-1:0] r_ridx, n_ridx;
    logic [7:0]           r_pend, n_pend;
    logic                 r_pend_v, n_pend_v;
    logic                 r_ov;
    t_out_word            r_out;

    logic [LEN_W-1:0] plen, rlen, cmp_len;
    logic             agree, full_match, part_match;
    logic             in_take, cfg_we, out_free, emit_ok;
    logic             do_emit, push;
    logic [7:0]       emit_byte;
    t_out_word        push_word;

    assign plen = clamp_len(r_plen_raw, LEN_W'(PLEN_CAP));
    assign rlen = clamp_len(r_rlen_raw, LEN_W'(RLEN_CAP));

    // Handshakes; an offered text word keeps configuration out
    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_valid;
    assign in_take     = i_valid && !o_stall;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_ov || !i_stall;
    assign emit_ok     = !r_pend_v || out_free;
    assign o_valid     = r_ov;
    assign o_data      = r_out;

    // Shared compare unit: window prefix against pattern prefix
    assign cmp_len = (r_len < plen) ? r_len : plen;
    always_comb begin
        agree = 1'b1;
        for (int i = 0; i < WINDOW_CAP; i++) begin
            if ((LEN_W'(i) < cmp_len) && (r_win[i] != r_pat[8*i +: 8])) begin
                agree = 1'b0;
            end
        end
    end
    assign full_match = (plen != '0) && agree && (r_len == plen);
    assign part_match = (plen != '0) && agree && (r_len < plen);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (full_match) begin
                    n_state = (rlen != '0) ? ST_REPL : ST_FINAL;
                end else if (part_match) begin
                    n_state = r_end ? ST_FLUSH : ST_FINAL;
                end else if (emit_ok && (r_len == LEN_W'(1))) begin
                    n_state = ST_FINAL;
                end
            end
            ST_REPL: begin
                if (emit_ok && ({1'b0, r_ridx} == rlen - LEN_W'(1))) n_state = ST_FINAL;
            end
            ST_FLUSH: begin
                if (emit_ok && (r_len == LEN_W'(1))) n_state = ST_FINAL;
            end
            ST_FINAL: begin
                if (r_end || r_pend_v) begin
                    if (out_free) n_state = ST_IDLE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and emit control
    always_comb begin
        n_win     = r_win;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_end     = r_end;
        n_ridx    = r_ridx;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        do_emit   = 1'b0;
        emit_byte = r_win[0];
        push      = 1'b0;
        push_word = '{out_byte: r_pend, byte_valid: 1'b1, last: 1'b0,
                      replacement_count: '0};
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_win[r_len[WIN_IDX_W-1:0]] = i_data.text_byte;
                    n_len  = r_len + LEN_W'(1);
                    n_end  = i_data.end_of_text;
                    n_ridx = '0;
                end
                if (cfg_we && ((t_cfg_idx'(i_cfg_index) == CFG_PATTERN_BYTES) ||
                               (t_cfg_idx'(i_cfg_index) == CFG_PATTERN_LENGTH))) begin
                    n_len = '0;
                end
            end
            ST_SCAN: begin
                if (full_match) begin
                    n_len  = '0;
                    n_ridx = '0;
                    if (r_cnt != '1) n_cnt = r_cnt + CNT_W'(1);
                end else if (!part_match && emit_ok) begin
                    do_emit   = 1'b1;
                    emit_byte = r_win[0];
                end
            end
            ST_REPL: begin
                if (emit_ok) begin
                    do_emit   = 1'b1;
                    emit_byte = r_rep[8*r_ridx +: 8];
                    n_ridx    = r_ridx + WIN_IDX_W'(1);
                end
            end
            ST_FLUSH: begin
                if (emit_ok) begin
                    do_emit   = 1'b1;
                    emit_byte = r_win[0];
                end
            end
            ST_FINAL: begin
                if (r_end) begin
                    if (out_free) begin
                        push      = 1'b1;
                        push_word = '{out_byte: r_pend_v ? r_pend : 8'd0,
                                      byte_valid: r_pend_v, last: 1'b1,
                                      replacement_count: r_cnt};
                        n_pend_v  = 1'b0;
                        n_cnt     = '0;
                        n_len     = '0;
                    end
                end else if (r_pend_v && out_free) begin
                    push     = 1'b1;
                    n_pend_v = 1'b0;
                end
            end
            default: ;
        endcase

        // Window bytes leave from the front
        if (do_emit && (r_state != ST_REPL)) begin
            for (int i = 0; i < WINDOW_CAP - 1; i++) begin
                n_win[i] = r_win[i+1];
            end
            n_len = r_len - LEN_W'(1);
        end

        // One byte staged so the final result can be flagged last
        if (do_emit) begin
            if (r_pend_v) push = 1'b1;
            n_pend   = emit_byte;
            n_pend_v = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_len      <= '0;
            r_cnt      <= '0;
            r_pend_v   <= 1'b0;
            r_ov       <= 1'b0;
            r_pat      <= '0;
            r_plen_raw <= '0;
            r_rep      <= '0;
            r_rlen_raw <= '0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
            if (push) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PATTERN_BYTES:      r_pat      <= i_cfg_data;
                    CFG_PATTERN_LENGTH:     r_plen_raw <= i_cfg_data[LEN_W-1:0];
                    CFG_REPLACEMENT_BYTES:  r_rep      <= i_cfg_data;
                    CFG_REPLACEMENT_LENGTH: r_rlen_raw <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_end  <= n_end;
        r_ridx <= n_ridx;
        r_pend <= n_pend;
        if (push) r_out <= push_word;
    end

    // A held partial match is always shorter than the pattern
    a_held_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && (r_len != '0)) |-> (r_len < plen))
        else $error("held window not shorter than pattern");

    // Nothing stays staged once a word is resolved
    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("staged byte left over at idle");

    // The end-of-text result clears count and window
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINAL) && r_end && out_free) |=>
        ((r_cnt == '0) && (r_len == '0) && r_ov && o_data.last))
        else $error("end of text did not clear state");

    // Replacement index stays inside the replacement
    a_ridx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPL) |-> ({1'b0, r_ridx} < rlen))
        else $error("replacement index out of range");

endmodule
